// ----- design/ssf_pkg.sv -----
package ssf_pkg;

   // Field widths of the request and response words
   localparam int CMD_W       = 2;
   localparam int BYTE_W      = 8;
   localparam int LOAD_ADDR_W = 19;
   localparam int PTR_W       = 24;
   localparam int POS_W       = 8;

   // Request word commands
   typedef enum logic [CMD_W-1:0] {
      CMD_EXCHANGE = 2'd0,
      CMD_DESELECT = 2'd1,
      CMD_PRELOAD  = 2'd2
   } cmd_type;

   // Flash opcodes
   localparam logic [BYTE_W-1:0] OP_READ      = 8'h03;
   localparam logic [BYTE_W-1:0] OP_FAST_READ = 8'hEB;
   localparam logic [BYTE_W-1:0] OP_READ_ID   = 8'h9F;

   // Identification bytes returned by read ID
   localparam logic [BYTE_W-1:0] ID_MAKER    = 8'hC2;
   localparam logic [BYTE_W-1:0] ID_KIND     = 8'h22;
   localparam logic [BYTE_W-1:0] ID_CAPACITY = 8'h13;

   localparam logic [BYTE_W-1:0] ERASED_BYTE = 8'hFF;
   localparam logic [PTR_W-1:0]  PTR_TOP     = 24'hFFFFFF;

   // Byte positions within a transaction, counted from one at the opcode
   localparam logic [POS_W-1:0] POS_ADDR_HI    = 8'd2;
   localparam logic [POS_W-1:0] POS_ADDR_MID   = 8'd3;
   localparam logic [POS_W-1:0] POS_ADDR_LO    = 8'd4;
   localparam logic [POS_W-1:0] POS_LAST_ADDR  = 8'd4;
   localparam logic [POS_W-1:0] POS_LAST_DUMMY = 8'd7;
   localparam logic [POS_W-1:0] POS_MAX        = 8'd255;

   // What the sequencer hands to the response stage for one word
   typedef struct packed {
      logic              use_mem;
      logic [BYTE_W-1:0] reply_byte;
      logic              unknown_command;
   } ssf_issue_type;

endpackage

// ----- design/ssf_req_if.sv -----
interface ssf_req_if;
   import ssf_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [CMD_W-1:0]       cmd;
   logic [BYTE_W-1:0]      data_byte;
   logic [LOAD_ADDR_W-1:0] load_address;

   modport source (output valid, output cmd, output data_byte, output load_address,
                   input ready);
   modport sink (input valid, input cmd, input data_byte, input load_address,
                 output ready);
endinterface

// ----- design/ssf_rsp_if.sv -----
interface ssf_rsp_if;
   import ssf_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] reply_byte;
   logic              unknown_command;

   modport source (output valid, output reply_byte, output unknown_command, input ready);
   modport sink (input valid, input reply_byte, input unknown_command, output ready);
endinterface

// ----- design/ssf_ram.sv -----
module ssf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- design/ssf_seq.sv -----
module ssf_seq #(
   parameter int SAVE_BYTES = 524288
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           accept,
   input  logic [ssf_pkg::CMD_W-1:0]       cmd,
   input  logic [ssf_pkg::BYTE_W-1:0]      data_byte,
   input  logic [ssf_pkg::LOAD_ADDR_W-1:0] load_address,
   output logic                           busy,
   output ssf_pkg::ssf_issue_type          issue,
   output logic                           wr_en,
   output logic [$clog2(SAVE_BYTES)-1:0]  wr_addr,
   output logic [ssf_pkg::BYTE_W-1:0]      wr_data,
   output logic                           rd_en,
   output logic [$clog2(SAVE_BYTES)-1:0]  rd_addr
);
   import ssf_pkg::*;

   localparam int ADDR_W = $clog2(SAVE_BYTES);
   localparam int SPAN_W = PTR_W + 1;
   localparam logic [SPAN_W-1:0] SPAN       = SPAN_W'(SAVE_BYTES);
   localparam logic [ADDR_W-1:0] LAST_ENTRY = ADDR_W'(SAVE_BYTES - 1);

   logic              clearing_ff, clearing_in;
   logic [ADDR_W-1:0] clear_addr_ff, clear_addr_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [BYTE_W-1:0] opcode_ff, opcode_in;
   logic [PTR_W-1:0]  ptr_ff, ptr_in;

   logic              first;
   logic [POS_W-1:0]  pos_step;
   logic [POS_W-1:0]  last_setup;
   logic [BYTE_W-1:0] opcode_cur;
   logic [PTR_W-1:0]  ptr_cur;
   logic              is_read;
   logic              in_range;

   // The opcode word latches the command and clears the pointer
   assign first      = (pos_ff == '0);
   assign pos_step   = (pos_ff == POS_MAX) ? pos_ff : pos_ff + POS_W'(1);
   assign opcode_cur = first ? data_byte : opcode_ff;
   assign ptr_cur    = first ? '0 : ptr_ff;
   assign is_read    = (opcode_cur == OP_READ) || (opcode_cur == OP_FAST_READ);
   assign last_setup = (opcode_cur == OP_FAST_READ) ? POS_LAST_DUMMY : POS_LAST_ADDR;
   assign in_range   = ({1'b0, ptr_cur} < SPAN);
   assign rd_addr    = ptr_cur[ADDR_W-1:0];
   assign busy       = clearing_ff;

   always_comb begin
      clearing_in   = clearing_ff;
      clear_addr_in = clear_addr_ff;
      pos_in        = pos_ff;
      opcode_in     = opcode_ff;
      ptr_in        = ptr_ff;
      issue         = '0;
      rd_en         = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = ADDR_W'(load_address);
      wr_data       = data_byte;

      if (clearing_ff) begin
         // erase sweep, one entry a cycle
         wr_en         = 1'b1;
         wr_addr       = clear_addr_ff;
         wr_data       = ERASED_BYTE;
         clear_addr_in = clear_addr_ff + ADDR_W'(1);
         if (clear_addr_ff == LAST_ENTRY) begin
            clearing_in = 1'b0;
         end
      end else if (accept) begin
         case (cmd)
            CMD_EXCHANGE: begin
               pos_in    = pos_step;
               opcode_in = opcode_cur;
               ptr_in    = ptr_cur;
               if (is_read) begin
                  if (pos_step <= last_setup) begin
                     case (pos_step)
                        POS_ADDR_HI:  ptr_in = ptr_cur | {data_byte, 16'h0000};
                        POS_ADDR_MID: ptr_in = ptr_cur | {8'h00, data_byte, 8'h00};
                        POS_ADDR_LO:  ptr_in = ptr_cur | {16'h0000, data_byte};
                        default:      ptr_in = ptr_cur;
                     endcase
                  end else if (in_range) begin
                     rd_en         = 1'b1;
                     issue.use_mem = 1'b1;
                     if (ptr_cur != PTR_TOP) begin
                        ptr_in = ptr_cur + PTR_W'(1);
                     end
                  end else begin
                     issue.reply_byte = ERASED_BYTE;
                  end
               end else if (opcode_cur == OP_READ_ID) begin
                  case (pos_step)
                     POS_ADDR_HI:  issue.reply_byte = ID_MAKER;
                     POS_ADDR_MID: issue.reply_byte = ID_KIND;
                     POS_ADDR_LO:  issue.reply_byte = ID_CAPACITY;
                     default:      issue.reply_byte = ERASED_BYTE;
                  endcase
               end else begin
                  issue.unknown_command = 1'b1;
               end
            end
            CMD_DESELECT: pos_in = '0;
            CMD_PRELOAD: begin
               if (SPAN_W'(load_address) < SPAN) begin
                  wr_en = 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff   <= 1'b1;
         clear_addr_ff <= '0;
         pos_ff        <= '0;
         opcode_ff     <= '0;
         ptr_ff        <= '0;
      end else begin
         clearing_ff   <= clearing_in;
         clear_addr_ff <= clear_addr_in;
         pos_ff        <= pos_in;
         opcode_ff     <= opcode_in;
         ptr_ff        <= ptr_in;
      end
   end

   a_no_accept_while_clearing: assert property (@(posedge clock) disable iff (reset)
      accept |-> !clearing_ff)
      else $error("word accepted during erase sweep");

   a_port_exclusive: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> !wr_en)
      else $error("save read and write in one cycle");

   a_read_in_range: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> ({1'b0, ptr_cur} < SPAN))
      else $error("save read beyond end of store");
endmodule

// ----- design/ssf_out.sv -----
module ssf_out (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      accept,
   input  ssf_pkg::ssf_issue_type     issue,
   input  logic [ssf_pkg::BYTE_W-1:0] rd_data,
   output logic                      can_take,
   ssf_rsp_if.source                 rsp
);
   import ssf_pkg::*;

   logic              s1_valid_ff, s1_valid_in;
   ssf_issue_type     s1_ff, s1_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] reply_ff, reply_in;
   logic              unknown_ff, unknown_in;
   logic              advance;

   // Stage one waits for the save read; the response register holds the word
   assign advance  = s1_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign can_take = !s1_valid_ff || !rsp_valid_ff || rsp.ready;

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_in        = s1_ff;
      rsp_valid_in = rsp_valid_ff;
      reply_in     = reply_ff;
      unknown_in   = unknown_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
         s1_in       = issue;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
      if (advance) begin
         rsp_valid_in = 1'b1;
         reply_in     = s1_ff.use_mem ? rd_data : s1_ff.reply_byte;
         unknown_in   = s1_ff.unknown_command;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      s1_ff      <= s1_in;
      reply_ff   <= reply_in;
      unknown_ff <= unknown_in;
   end

   assign rsp.valid           = rsp_valid_ff;
   assign rsp.reply_byte      = reply_ff;
   assign rsp.unknown_command = unknown_ff;

   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_valid_ff)
      else $error("accepted word did not reach stage one");

   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !advance |=> s1_valid_ff && $stable(s1_ff))
      else $error("stalled stage one word lost");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      accept |-> can_take)
      else $error("word accepted with stage one full");
endmodule

// ----- design/spi_save_flash_responder.sv -----
// Serial save flash responder: each request word is one byte exchanged on the
// flash bus (or a deselect, or a preload of one save byte) and yields exactly
// one response word. Supported opcodes are read (03h, three address bytes),
// fast read (EBh, address plus three dummy bytes) and read ID (9Fh, C2h 22h
// 13h then FFh); any other opcode answers 0 with unknown_command set. Reads
// past the end of the store answer FFh. After reset the block erases the
// whole store to FFh, one byte a cycle, and req.ready stays low until the
// sweep is done. From then on a word is taken every cycle while the
// response side keeps up; each word passes through stage one, which waits
// for the registered save RAM read, and then the response register, which
// holds the reply until it is taken.
module spi_save_flash_responder #(
   parameter int SAVE_BYTES = 524288
) (
   input logic       clock,
   input logic       reset,
   ssf_req_if.sink   req,
   ssf_rsp_if.source rsp
);
   import ssf_pkg::*;

   localparam int ADDR_W = $clog2(SAVE_BYTES);

   logic              accept;
   logic              busy;
   logic              can_take;
   ssf_issue_type     issue;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [BYTE_W-1:0] wr_data;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [BYTE_W-1:0] rd_data;

   // take a word only once the erase sweep is done and stage one has room
   assign req.ready = !busy && can_take;
   assign accept    = req.valid && req.ready;

   // transaction tracking, read pointer and the erase sweep
   ssf_seq #(
      .SAVE_BYTES (SAVE_BYTES)
   ) u_seq (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .cmd          (req.cmd),
      .data_byte    (req.data_byte),
      .load_address (req.load_address),
      .busy         (busy),
      .issue        (issue),
      .wr_en        (wr_en),
      .wr_addr      (wr_addr),
      .wr_data      (wr_data),
      .rd_en        (rd_en),
      .rd_addr      (rd_addr)
   );

   // save store, one write port and one registered read port
   ssf_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (SAVE_BYTES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // stage one and the response register
   ssf_out u_out (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .issue    (issue),
      .rd_data  (rd_data),
      .can_take (can_take),
      .rsp      (rsp)
   );
endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps

module tb;
   import ssf_pkg::*;

   localparam int SAVE_BYTES = 524288;

   // The request command field is two bits wide; the top code is unused and
   // must leave every piece of state alone.
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   // The opcode itself sits at the first byte after a deselect.
   localparam logic [POS_W-1:0] POS_OPCODE = 8'd1;

   // The limit covers the erase pass after reset, with plenty on top.
   localparam int LIMIT_CYCLES = 4 * (SAVE_BYTES + 50000);
   localparam int DRAIN_CYCLES = 20;

   // Hot windows at the bottom and the top of the store, so reads meet preloaded bytes
   localparam logic [23:0] LOW_WINDOW  = 24'h000000;
   localparam logic [23:0] HIGH_WINDOW = 24'h07FC00;

   typedef struct packed {
      logic [CMD_W-1:0]       cmd;
      logic [BYTE_W-1:0]      data_byte;
      logic [LOAD_ADDR_W-1:0] load_address;
   } flash_word_type;

   typedef struct packed {
      logic [BYTE_W-1:0] reply_byte;
      logic              unknown_command;
   } flash_reply_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ssf_req_if req_ch ();
   ssf_rsp_if rsp_ch ();

   spi_save_flash_responder #(
      .SAVE_BYTES(SAVE_BYTES)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req  (req_ch),
      .rsp  (rsp_ch)
   );

   // 12 ns period
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Words waiting to be sent, and replies awaited from the block
   flash_word_type  bus_words[$];
   flash_reply_type awaited_replies[$];
   int              words_queued = 0;
   int              err_count    = 0;
   int              cycle_count  = 0;

   // Idle rates in percent, changed from phase to phase
   int           send_idle_pct = 14;
   int           recv_idle_pct = 74;

   logic         req_taken;

   // Shadow of the flash state
   logic [BYTE_W-1:0] save_image[bit [LOAD_ADDR_W-1:0]];
   logic [POS_W-1:0]  pos_count   = '0;
   logic [BYTE_W-1:0] opcode_held = '0;
   logic [PTR_W-1:0]  fetch_ptr   = '0;

   // Work out the reply to one accepted word and advance the shadow state.
   function automatic flash_reply_type flash_respond(input flash_word_type w);
      flash_reply_type  r;
      logic [POS_W-1:0] setup_end;
      r = '0;
      case (w.cmd)
         CMD_EXCHANGE: begin
            // Count saturates, so a very long transaction keeps its opcode
            if (pos_count != POS_MAX)
               pos_count = pos_count + 1'b1;
            if (pos_count == POS_OPCODE) begin
               opcode_held = w.data_byte;
               fetch_ptr   = '0;
            end
            if (opcode_held == OP_READ || opcode_held == OP_FAST_READ) begin
               setup_end = (opcode_held == OP_FAST_READ) ? POS_LAST_DUMMY : POS_LAST_ADDR;
               if (pos_count <= setup_end) begin
                  // Address bytes arrive most significant first; dummies are dropped
                  if (pos_count >= POS_ADDR_HI && pos_count <= POS_ADDR_LO)
                     fetch_ptr = fetch_ptr |
                        ({16'd0, w.data_byte} << (8 * (POS_ADDR_LO - pos_count)));
               end else if (fetch_ptr < SAVE_BYTES) begin
                  r.reply_byte = save_image.exists(fetch_ptr[LOAD_ADDR_W-1:0]) ?
                                 save_image[fetch_ptr[LOAD_ADDR_W-1:0]] : ERASED_BYTE;
                  if (fetch_ptr != PTR_TOP)
                     fetch_ptr = fetch_ptr + 1'b1;
               end else begin
                  // Past the end of the store: erased pattern, pointer holds
                  r.reply_byte = ERASED_BYTE;
               end
            end else if (opcode_held == OP_READ_ID) begin
               case (pos_count)
                  POS_ADDR_HI:  r.reply_byte = ID_MAKER;
                  POS_ADDR_MID: r.reply_byte = ID_KIND;
                  POS_ADDR_LO:  r.reply_byte = ID_CAPACITY;
                  default:      r.reply_byte = ERASED_BYTE;
               endcase
            end else begin
               r.unknown_command = 1'b1;
            end
         end
         CMD_DESELECT: pos_count = '0;
         CMD_PRELOAD: begin
            if (w.load_address < SAVE_BYTES)
               save_image[w.load_address] = w.data_byte;
         end
         default: ;
      endcase
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Stimulus building blocks
   // ------------------------------------------------------------------
   task automatic queue_word(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] data_byte,
                             input logic [LOAD_ADDR_W-1:0] load_address);
      flash_word_type w;
      w.cmd          = cmd;
      w.data_byte    = data_byte;
      w.load_address = load_address;
      bus_words.push_back(w);
      words_queued++;
   endtask

   // Exchanges and deselects carry random junk in the unused fields
   task automatic queue_exchange(input logic [BYTE_W-1:0] b);
      queue_word(CMD_EXCHANGE, b, LOAD_ADDR_W'($urandom));
   endtask

   task automatic queue_deselect();
      queue_word(CMD_DESELECT, BYTE_W'($urandom), LOAD_ADDR_W'($urandom));
   endtask

   // Deselect, opcode, three address bytes, dummies for fast read, then data
   task automatic queue_read(input logic [BYTE_W-1:0] op, input logic [23:0] start,
                             input int n_data);
      queue_deselect();
      queue_exchange(op);
      queue_exchange(start[23:16]);
      queue_exchange(start[15:8]);
      queue_exchange(start[7:0]);
      if (op == OP_FAST_READ)
         repeat (3) queue_exchange(BYTE_W'($urandom));
      repeat (n_data) queue_exchange(BYTE_W'($urandom));
   endtask

   task automatic queue_read_id(input int n_after);
      queue_deselect();
      queue_exchange(OP_READ_ID);
      repeat (n_after) queue_exchange(BYTE_W'($urandom));
   endtask

   function automatic logic [23:0] hot_address();
      return ($urandom_range(0, 1) ? HIGH_WINDOW : LOW_WINDOW) + 24'($urandom_range(0, 1023));
   endfunction

   // Mostly well-formed transactions with random content, the rest broken
   // sequences and loose words.
   task automatic queue_traffic(input int n_words);
      int                     target;
      int                     pick;
      int                     len;
      logic [23:0]            start;
      logic [LOAD_ADDR_W-1:0] base;
      logic [BYTE_W-1:0]      op;
      target = words_queued + n_words;
      while (words_queued < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 20) begin
            // Burst of preloads, mostly into a hot window
            base = ($urandom_range(0, 3) == 0) ? LOAD_ADDR_W'($urandom) :
                                                 LOAD_ADDR_W'(hot_address());
            len = $urandom_range(1, 8);
            for (int i = 0; i < len; i++)
               queue_word(CMD_PRELOAD, BYTE_W'($urandom), base + LOAD_ADDR_W'(i));
         end else if (pick < 60) begin
            op = $urandom_range(0, 1) ? OP_READ : OP_FAST_READ;
            queue_read(op, hot_address(), $urandom_range(1, 12));
         end else if (pick < 70) begin
            queue_read_id($urandom_range(0, 6));
         end else if (pick < 78) begin
            // Opcode the flash does not know
            do op = BYTE_W'($urandom);
            while (op == OP_READ || op == OP_FAST_READ || op == OP_READ_ID);
            queue_deselect();
            queue_exchange(op);
            repeat ($urandom_range(0, 3)) queue_exchange(BYTE_W'($urandom));
         end else if (pick < 88) begin
            // Any 24-bit address, mostly beyond the store
            op = $urandom_range(0, 1) ? OP_READ : OP_FAST_READ;
            queue_read(op, 24'($urandom), $urandom_range(1, 4));
         end else if (pick < 95) begin
            // Cut short by a deselect before the setup is complete
            queue_deselect();
            queue_exchange($urandom_range(0, 1) ? OP_READ : OP_FAST_READ);
            repeat ($urandom_range(0, 2)) queue_exchange(BYTE_W'($urandom));
         end else begin
            // Loose word, now and then the unused command
            queue_word(($urandom_range(0, 9) == 0) ? CMD_UNUSED :
                       CMD_W'($urandom_range(0, 2)),
                       BYTE_W'($urandom), LOAD_ADDR_W'($urandom));
         end
      end
   endtask

   // Hold until every queued word has gone and every reply has come back.
   task automatic drain();
      while (bus_words.size() != 0 || req_ch.valid || awaited_replies.size() != 0)
         @(negedge clock);
   endtask

   // ------------------------------------------------------------------
   // Request driver: change inputs on the falling edge only
   // ------------------------------------------------------------------
   initial begin
      req_ch.valid        = 1'b0;
      req_ch.cmd          = '0;
      req_ch.data_byte    = '0;
      req_ch.load_address = '0;
      rsp_ch.ready        = 1'b0;
   end

   always @(negedge clock) begin : drive_req
      flash_word_type w;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_taken) begin
         // Previous word gone (or none pending): offer the next one, or idle
         if (bus_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            w = bus_words.pop_front();
            req_ch.valid        <= 1'b1;
            req_ch.cmd          <= w.cmd;
            req_ch.data_byte    <= w.data_byte;
            req_ch.load_address <= w.load_address;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
      // Stall the response side at the current rate
      rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // ------------------------------------------------------------------
   // Monitor: sample both channels on the rising edge
   // ------------------------------------------------------------------
   always @(posedge clock) begin : watch_bus
      flash_word_type  w;
      flash_reply_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_ch.valid && req_ch.ready;
         if (req_ch.valid && req_ch.ready) begin
            w.cmd          = req_ch.cmd;
            w.data_byte    = req_ch.data_byte;
            w.load_address = req_ch.load_address;
            awaited_replies.push_back(flash_respond(w));
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (awaited_replies.size() == 0) begin
               $display("%0t: reply with none awaited: expected nothing, actual %h/%b",
                        $time, rsp_ch.reply_byte, rsp_ch.unknown_command);
               err_count++;
            end else begin
               want = awaited_replies.pop_front();
               if (rsp_ch.reply_byte !== want.reply_byte) begin
                  $display("%0t: reply_byte mismatch: expected %h, actual %h",
                           $time, want.reply_byte, rsp_ch.reply_byte);
                  err_count++;
               end
               if (rsp_ch.unknown_command !== want.unknown_command) begin
                  $display("%0t: unknown_command mismatch: expected %b, actual %b",
                           $time, want.unknown_command, rsp_ch.unknown_command);
                  err_count++;
               end
            end
         end
      end
   end

   // Drop the run if it hangs
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Sequence of the run
   // ------------------------------------------------------------------
   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed words. Preload both ends of the store, then read the bottom
      // byte straight after reset.
      queue_word(CMD_PRELOAD, 8'h5A, '0);
      queue_word(CMD_PRELOAD, 8'hA5, '1);
      queue_read(OP_READ, 24'h000000, 1);
      // Fast read of the last byte, then one past the end
      queue_read(OP_FAST_READ, 24'h07FFFF, 2);
      // Read ID: opcode byte, the three ID bytes, then the erased pattern
      queue_read_id(4);
      // Unknown opcode with all bits set; the unused command in the middle
      // must not disturb the transaction
      queue_deselect();
      queue_exchange(8'hFF);
      queue_word(CMD_UNUSED, 8'hFF, '1);
      queue_exchange(8'h00);

      // Sender mostly busy, receiver mostly stalled
      queue_traffic(200);
      drain();

      // The other way round
      send_idle_pct = 74;
      recv_idle_pct = 14;
      queue_traffic(200);
      drain();

      // Full rate. Pointer just below its top, and one transaction long enough to
      // saturate the byte count while it runs off the end of the store.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      queue_read(OP_READ, 24'hFFFFFE, 3);
      queue_traffic(100);
      queue_read(OP_FAST_READ, 24'h07FF80, 265);
      queue_traffic(20);
      drain();

      // Let any stray reply show itself
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (err_count == 0 && awaited_replies.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

// ----- sim.f -----
design/ssf_pkg.sv
design/ssf_req_if.sv
design/ssf_rsp_if.sv
design/ssf_ram.sv
design/ssf_seq.sv
design/ssf_out.sv
design/spi_save_flash_responder.sv
dv/tb.sv
